// ===== sv/rwcw_pkg.sv =====
// ----------------------------------------------------------------------------
// rwcw_pkg
// Types and constants shared by the RIFF/WAVE chunk walker modules.
// ----------------------------------------------------------------------------
package rwcw_pkg;

  // Tags as they read in a little-endian 32-bit word
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [7:0] MIN_FORMAT_LENGTH_RESET = 8'd14;

  typedef enum logic [2:0] {
    ST_SCAN       = 3'd0,
    ST_FOUND      = 3'd1,
    ST_BAD_RIFF   = 3'd2,
    ST_BAD_WAVE   = 3'd3,
    ST_SHORT      = 3'd4,
    ST_INCOMPLETE = 3'd5,
    ST_IDLE       = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    PH_RIFF = 3'd0,
    PH_LEN  = 3'd1,
    PH_WAVE = 3'd2,
    PH_ID   = 3'd3,
    PH_CLEN = 3'd4,
    PH_BODY = 3'd5,
    PH_DONE = 3'd6
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] format_offset;
    logic [31:0] data_offset;
    logic [31:0] data_length;
  } result_t;

endpackage

// ===== sv/rwcw_step.sv =====
// ----------------------------------------------------------------------------
// rwcw_step
// Parser state and the per-byte update; produces one result per byte.
// ----------------------------------------------------------------------------
module rwcw_step (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  rwcw_pkg::item_t  item,
  input  logic [7:0]       min_format_length,
  output rwcw_pkg::result_t result
);

  rwcw_pkg::phase_t phase, phase_next;
  logic [1:0]  byte_in_word, byte_in_word_next;
  logic [31:0] word_shift, word_shift_next;
  logic [31:0] position, position_next;
  logic [32:0] riff_end, riff_end_next;
  logic [31:0] chunk_tag, chunk_tag_next;
  logic [32:0] body_remaining, body_remaining_next;
  logic        format_seen, format_seen_next;
  logic [31:0] format_start, format_start_next;
  logic [31:0] data_start, data_start_next;
  logic [31:0] data_size, data_size_next;
  logic        data_seen, data_seen_next;

  logic [31:0] word;
  logic        boundary;
  rwcw_pkg::status_t st;

  always_comb begin
    // first_byte restarts from the cleared state
    if (item.first_byte) begin
      phase_next          = rwcw_pkg::PH_RIFF;
      byte_in_word_next   = 2'd0;
      word_shift_next     = '0;
      position_next       = '0;
      riff_end_next       = '0;
      chunk_tag_next      = '0;
      body_remaining_next = '0;
      format_seen_next    = 1'b0;
      format_start_next   = '0;
      data_start_next     = '0;
      data_size_next      = '0;
      data_seen_next      = 1'b0;
    end else begin
      phase_next          = phase;
      byte_in_word_next   = byte_in_word;
      word_shift_next     = word_shift;
      position_next       = position;
      riff_end_next       = riff_end;
      chunk_tag_next      = chunk_tag;
      body_remaining_next = body_remaining;
      format_seen_next    = format_seen;
      format_start_next   = format_start;
      data_start_next     = data_start;
      data_size_next      = data_size;
      data_seen_next      = data_seen;
    end

    st       = rwcw_pkg::ST_SCAN;
    boundary = 1'b0;
    word     = {item.data_byte, word_shift_next[31:8]};

    case (phase_next)
      rwcw_pkg::PH_BODY: begin
        position_next       = position_next + 32'd1;
        body_remaining_next = body_remaining_next - 33'd1;
        boundary            = (body_remaining_next == 33'd0);
      end
      rwcw_pkg::PH_RIFF, rwcw_pkg::PH_LEN, rwcw_pkg::PH_WAVE,
      rwcw_pkg::PH_ID, rwcw_pkg::PH_CLEN: begin
        position_next     = position_next + 32'd1;
        word_shift_next   = word;
        byte_in_word_next = byte_in_word_next + 2'd1;
        if (byte_in_word_next == 2'd0) begin
          case (phase_next)
            rwcw_pkg::PH_RIFF: begin
              if (word != rwcw_pkg::TAG_RIFF) begin
                st         = rwcw_pkg::ST_BAD_RIFF;
                phase_next = rwcw_pkg::PH_DONE;
              end else begin
                phase_next = rwcw_pkg::PH_LEN;
              end
            end
            rwcw_pkg::PH_LEN: begin
              riff_end_next = {1'b0, word} + 33'd8;
              phase_next    = rwcw_pkg::PH_WAVE;
            end
            rwcw_pkg::PH_WAVE: begin
              if (word != rwcw_pkg::TAG_WAVE) begin
                st         = rwcw_pkg::ST_BAD_WAVE;
                phase_next = rwcw_pkg::PH_DONE;
              end else begin
                boundary = 1'b1;
              end
            end
            rwcw_pkg::PH_ID: begin
              chunk_tag_next = word;
              phase_next     = rwcw_pkg::PH_CLEN;
            end
            default: begin
              // chunk length field complete
              body_remaining_next = ({1'b0, word} + 33'd1) & ~33'd1;
              phase_next          = rwcw_pkg::PH_BODY;
              if (chunk_tag_next == rwcw_pkg::TAG_FMT && !format_seen_next) begin
                if (word < {24'd0, min_format_length}) begin
                  st         = rwcw_pkg::ST_SHORT;
                  phase_next = rwcw_pkg::PH_DONE;
                end else begin
                  format_seen_next  = 1'b1;
                  format_start_next = position_next;
                end
              end else if (chunk_tag_next == rwcw_pkg::TAG_DATA &&
                           (!data_seen_next || data_size_next == 32'd0)) begin
                data_seen_next  = 1'b1;
                data_start_next = position_next;
                data_size_next  = word;
                if (format_seen_next) begin
                  st         = rwcw_pkg::ST_FOUND;
                  phase_next = rwcw_pkg::PH_DONE;
                end
              end
              if (phase_next == rwcw_pkg::PH_BODY && body_remaining_next == 33'd0) begin
                boundary = 1'b1;
              end
            end
          endcase
        end
      end
      default: begin
        st = rwcw_pkg::ST_IDLE;
      end
    endcase

    // chunk boundary: next header or end of walk
    if (boundary) begin
      if ({1'b0, position_next} >= riff_end_next) begin
        st = (format_seen_next && data_seen_next) ? rwcw_pkg::ST_FOUND
                                                  : rwcw_pkg::ST_INCOMPLETE;
        phase_next = rwcw_pkg::PH_DONE;
      end else begin
        phase_next = rwcw_pkg::PH_ID;
      end
    end

    result.status = st;
    if (st == rwcw_pkg::ST_FOUND) begin
      result.format_offset = format_start_next;
      result.data_offset   = data_start_next;
      result.data_length   = data_size_next;
    end else begin
      result.format_offset = '0;
      result.data_offset   = '0;
      result.data_length   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= rwcw_pkg::PH_RIFF;
      byte_in_word   <= 2'd0;
      word_shift     <= '0;
      position       <= '0;
      riff_end       <= '0;
      chunk_tag      <= '0;
      body_remaining <= '0;
      format_seen    <= 1'b0;
      format_start   <= '0;
      data_start     <= '0;
      data_size      <= '0;
      data_seen      <= 1'b0;
    end else if (take) begin
      phase          <= phase_next;
      byte_in_word   <= byte_in_word_next;
      word_shift     <= word_shift_next;
      position       <= position_next;
      riff_end       <= riff_end_next;
      chunk_tag      <= chunk_tag_next;
      body_remaining <= body_remaining_next;
      format_seen    <= format_seen_next;
      format_start   <= format_start_next;
      data_start     <= data_start_next;
      data_size      <= data_size_next;
      data_seen      <= data_seen_next;
    end
  end

  // body skip only entered on a word boundary with bytes left
  assert property (@(posedge clk) disable iff (rst)
    (phase == rwcw_pkg::PH_BODY) |-> (byte_in_word == 2'd0 && body_remaining != 33'd0))
    else $error("body phase with bad counters");

  assert property (@(posedge clk) disable iff (rst)
    (phase == rwcw_pkg::PH_DONE && !item.first_byte) |-> (result.status == rwcw_pkg::ST_IDLE))
    else $error("finished walk not idle");

  assert property (@(posedge clk) disable iff (rst)
    (result.status != rwcw_pkg::ST_FOUND) |->
      (result.format_offset == '0 && result.data_offset == '0 && result.data_length == '0))
    else $error("offsets leaked without found status");

  assert property (@(posedge clk) disable iff (rst)
    (take && result.status != rwcw_pkg::ST_SCAN) |=> (phase == rwcw_pkg::PH_DONE))
    else $error("verdict did not end the walk");

endmodule

// ===== sv/rwcw_obuf.sv =====
// ----------------------------------------------------------------------------
// rwcw_obuf
// Result register; holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module rwcw_obuf (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  rwcw_pkg::result_t load_data,
  output logic              result_valid,
  input  logic              result_ready,
  output rwcw_pkg::result_t result
);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= load_data;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    load |=> result_valid)
    else $error("loaded result not presented");

  assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |-> !load)
    else $error("result overwritten before transaction");

  assert property (@(posedge clk) disable iff (rst)
    (!load && !result_valid) |=> !result_valid)
    else $error("result valid without load");

endmodule

// ===== sv/riff_wave_chunk_walker_core.sv =====
// Latency: a result appears in the cycle after its byte is accepted.
// Throughput: one byte per cycle; the parser state updates in a single pass.
// A byte is accepted while the result register is empty or being drained.
// Reset (rst, synchronous) clears the parser to the RIFF tag phase and sets
// min_format_length to 14. first_byte restarts the parser per file.
// ----------------------------------------------------------------------------
// riff_wave_chunk_walker_core
// Streams WAV bytes, walks RIFF chunks, reports fmt/data body offsets.
// ----------------------------------------------------------------------------
module riff_wave_chunk_walker_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  rwcw_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output rwcw_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_data
);

  logic              take;
  logic [7:0]        min_format_length;
  rwcw_pkg::result_t step_result;

  assign cfg_ready  = 1'b1;
  assign item_ready = !result_valid || result_ready;
  assign take       = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_format_length <= rwcw_pkg::MIN_FORMAT_LENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      min_format_length <= cfg_data;
    end
  end

  rwcw_step u_step (
    .clk               (clk),
    .rst               (rst),
    .take              (take),
    .item              (item),
    .min_format_length (min_format_length),
    .result            (step_result)
  );

  rwcw_obuf u_obuf (
    .clk          (clk),
    .rst          (rst),
    .load         (take),
    .load_data    (step_result),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |-> !item_ready)
    else $error("input taken while result stalled");

  assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |=> (min_format_length == $past(cfg_data)))
    else $error("config write lost");

  // a stalled result holds until its transaction
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> (result_valid && $stable(result)))
    else $error("stalled result changed");

endmodule

// ===== sim/riff_wave_chunk_walker_checker.sv =====
// ----------------------------------------------------------------------------
// riff_wave_chunk_walker_checker
// Watches the byte, result and register channels of the chunk walker. Keeps
// its own copy of the parser state, queues the result due for every byte
// transaction and compares each result transaction against the oldest one.
// ----------------------------------------------------------------------------
module riff_wave_chunk_walker_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_ready,
  input  rwcw_pkg::item_t   item,
  input  logic              result_valid,
  input  logic              result_ready,
  input  rwcw_pkg::result_t result,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [7:0]        cfg_data,
  output int                mismatches,
  output int                outstanding
);

  rwcw_pkg::phase_t phase;
  logic [1:0]  byte_cnt;
  logic [31:0] shift_word;
  logic [31:0] pos;
  logic [32:0] walk_end;
  logic [31:0] chunk_id;
  logic [32:0] body_left;
  logic        fmt_seen;
  logic [31:0] fmt_pos;
  logic [31:0] data_pos;
  logic [31:0] data_len;
  logic        data_seen;
  logic        done;
  logic [7:0]  min_fmt = rwcw_pkg::MIN_FORMAT_LENGTH_RESET;

  rwcw_pkg::result_t due_results[$];
  int          fail_n = 0;
  int          shown = 0;
  int          backlog = 0;

  assign mismatches  = fail_n;
  assign outstanding = backlog;

  function automatic void clear_walk();
    phase      = rwcw_pkg::PH_RIFF;
    byte_cnt   = '0;
    shift_word = '0;
    pos        = '0;
    walk_end   = '0;
    chunk_id   = '0;
    body_left  = '0;
    fmt_seen   = 1'b0;
    fmt_pos    = '0;
    data_pos   = '0;
    data_len   = '0;
    data_seen  = 1'b0;
    done       = 1'b0;
  endfunction

  function automatic rwcw_pkg::status_t conclude(rwcw_pkg::status_t s);
    done  = 1'b1;
    phase = rwcw_pkg::PH_DONE;
    return s;
  endfunction

  // chunk boundary: open the next header or close the walk
  function automatic rwcw_pkg::status_t next_or_end();
    if ({1'b0, pos} >= walk_end) begin
      if (fmt_seen && data_seen) return conclude(rwcw_pkg::ST_FOUND);
      return conclude(rwcw_pkg::ST_INCOMPLETE);
    end
    phase = rwcw_pkg::PH_ID;
    return rwcw_pkg::ST_SCAN;
  endfunction

  function automatic rwcw_pkg::status_t length_field(logic [31:0] len);
    if (chunk_id == rwcw_pkg::TAG_FMT) begin
      if (!fmt_seen) begin
        if (len < {24'd0, min_fmt}) return conclude(rwcw_pkg::ST_SHORT);
        fmt_seen = 1'b1;
        fmt_pos  = pos;
      end
    end else if (chunk_id == rwcw_pkg::TAG_DATA) begin
      // an empty data chunk may be superseded by a later one
      if (!data_seen || data_len == '0) begin
        data_seen = 1'b1;
        data_pos  = pos;
        data_len  = len;
        if (fmt_seen) return conclude(rwcw_pkg::ST_FOUND);
      end
    end
    body_left = ({1'b0, len} + 33'd1) & ~33'd1;
    if (body_left == '0) return next_or_end();
    phase = rwcw_pkg::PH_BODY;
    return rwcw_pkg::ST_SCAN;
  endfunction

  function automatic rwcw_pkg::result_t walk_byte(rwcw_pkg::item_t it);
    rwcw_pkg::status_t st;
    logic [31:0]       w;
    rwcw_pkg::result_t r;
    if (it.first_byte) clear_walk();
    st = rwcw_pkg::ST_IDLE;
    if (!done && phase != rwcw_pkg::PH_DONE) begin
      pos = pos + 32'd1;
      st  = rwcw_pkg::ST_SCAN;
      if (phase == rwcw_pkg::PH_BODY) begin
        body_left = body_left - 33'd1;
        if (body_left == '0) st = next_or_end();
      end else begin
        shift_word = {it.data_byte, shift_word[31:8]};
        byte_cnt   = byte_cnt + 2'd1;
        if (byte_cnt == 2'd0) begin
          w = shift_word;
          case (phase)
            rwcw_pkg::PH_RIFF: begin
              if (w != rwcw_pkg::TAG_RIFF) st = conclude(rwcw_pkg::ST_BAD_RIFF);
              else phase = rwcw_pkg::PH_LEN;
            end
            rwcw_pkg::PH_LEN: begin
              walk_end = {1'b0, w} + 33'd8;
              phase    = rwcw_pkg::PH_WAVE;
            end
            rwcw_pkg::PH_WAVE: begin
              if (w != rwcw_pkg::TAG_WAVE) st = conclude(rwcw_pkg::ST_BAD_WAVE);
              else st = next_or_end();
            end
            rwcw_pkg::PH_ID: begin
              chunk_id = w;
              phase    = rwcw_pkg::PH_CLEN;
            end
            rwcw_pkg::PH_CLEN: st = length_field(w);
            default: ;
          endcase
        end
      end
    end
    r = '0;
    r.status = st;
    if (st == rwcw_pkg::ST_FOUND) begin
      r.format_offset = fmt_pos;
      r.data_offset   = data_pos;
      r.data_length   = data_len;
    end
    return r;
  endfunction

  task automatic log_fail(string msg);
    fail_n++;
    if (shown < 10) begin
      shown++;
      $display("%0t: %s", $time, msg);
    end
  endtask

  always @(posedge clk) begin
    rwcw_pkg::result_t want;
    if (rst) begin
      clear_walk();
      min_fmt = rwcw_pkg::MIN_FORMAT_LENGTH_RESET;
      due_results.delete();
    end else begin
      if (result_valid && result_ready) begin
        if (due_results.size() == 0) begin
          log_fail($sformatf("result with nothing due: status %0d fmt %h data %h len %h",
                             result.status, result.format_offset, result.data_offset,
                             result.data_length));
        end else begin
          want = due_results.pop_front();
          if (result.status !== want.status ||
              result.format_offset !== want.format_offset ||
              result.data_offset !== want.data_offset ||
              result.data_length !== want.data_length) begin
            log_fail($sformatf({"mismatch: expected status %0d fmt %h data %h len %h, ",
                                "actual status %0d fmt %h data %h len %h"},
                               want.status, want.format_offset, want.data_offset,
                               want.data_length, result.status, result.format_offset,
                               result.data_offset, result.data_length));
          end
        end
      end
      // a byte taken at the same edge as a register write still sees the old value
      if (item_valid && item_ready) due_results.push_back(walk_byte(item));
      if (cfg_valid && cfg_ready) min_fmt = cfg_data;
    end
    backlog <= due_results.size();
  end

endmodule

// ===== sim/tb_riff_wave_chunk_walker_core.sv =====
// ----------------------------------------------------------------------------
// tb_riff_wave_chunk_walker_core
// Feeds the chunk walker WAV byte streams: a directed set of files for the
// tag errors, walk-end, padding and data/fmt ordering cases, then random
// well-formed, damaged and noise streams under several fmt length minimums,
// with random idle bursts on both channels. The checker scores every result.
// ----------------------------------------------------------------------------
module tb_riff_wave_chunk_walker_core;

  localparam logic [31:0] TAG_LIST = 32'h5453_494C;
  localparam logic [31:0] TAG_RIFX = 32'h5846_4952;
  localparam logic [31:0] TAG_WAVX = 32'h5856_4157;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              item_valid = 1'b0;
  logic              item_ready;
  rwcw_pkg::item_t   item = '0;
  logic              result_valid;
  logic              result_ready = 1'b0;
  rwcw_pkg::result_t result;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [7:0]        cfg_data = '0;

  int         mismatches;
  int         outstanding;
  int         idle_pct = 0;
  int         stall_left = 0;
  int         bytes_sent = 0;
  int         min_fmt_now = int'(rwcw_pkg::MIN_FORMAT_LENGTH_RESET);
  logic [7:0] chunk_q[$];

  riff_wave_chunk_walker_core dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  riff_wave_chunk_walker_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("[riff_wave_chunk_walker_core] ERROR");
    $finish;
  end

  // random result side backpressure in bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      result_ready <= 1'b0;
    end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct / 2) begin
      stall_left   <= $urandom_range(0, 17);
      result_ready <= 1'b0;
    end else begin
      result_ready <= 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fb);
    int gap;
    gap = 0;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) gap = $urandom_range(1, 18);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= '{data_byte: b, first_byte: fb};
    do @(posedge clk); while (!item_ready);
  endtask

  task automatic put_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) chunk_q.push_back(w[8*i +: 8]);
  endtask

  task automatic put_header(input logic [31:0] tag, input logic [31:0] len);
    put_word(tag);
    put_word(len);
  endtask

  // header plus the whole body, padded to even size
  task automatic put_chunk(input logic [31:0] tag, input int len);
    put_header(tag, 32'(len));
    repeat (len + (len & 1)) chunk_q.push_back(8'($urandom_range(0, 255)));
  endtask

  function automatic logic [31:0] riff_size();
    return 32'(4 + chunk_q.size());
  endfunction

  task automatic send_wav(input logic [31:0] riff_tag, input logic [31:0] len,
                          input logic [31:0] wave_tag, input int tail_n);
    logic [31:0] head [3];
    head = '{riff_tag, len, wave_tag};
    for (int k = 0; k < 3; k++)
      for (int i = 0; i < 4; i++) send_byte(head[k][8*i +: 8], k == 0 && i == 0);
    foreach (chunk_q[i]) send_byte(chunk_q[i], 1'b0);
    repeat (tail_n) send_byte(8'($urandom_range(0, 255)), 1'b0);
    bytes_sent += 12 + chunk_q.size() + tail_n;
    chunk_q.delete();
  endtask

  // register writes only once every result has drained
  task automatic set_min_format(input logic [7:0] v);
    item_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (2) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    min_fmt_now = v;
  endtask

  task automatic directed_files();
    idle_pct = 20;
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_wav(TAG_RIFX, 32'd4, rwcw_pkg::TAG_WAVE, 2);
    send_wav(rwcw_pkg::TAG_RIFF, 32'd4, TAG_WAVX, 1);
    // zero RIFF length ends the walk right after the form type
    put_chunk(rwcw_pkg::TAG_FMT, 16);
    send_wav(rwcw_pkg::TAG_RIFF, 32'd0, rwcw_pkg::TAG_WAVE, 0);
    put_chunk(rwcw_pkg::TAG_FMT, 16);
    put_chunk(rwcw_pkg::TAG_DATA, 4);
    send_wav(rwcw_pkg::TAG_RIFF, riff_size(), rwcw_pkg::TAG_WAVE, 0);
    // data ahead of fmt, odd size, fmt exactly at the minimum
    put_chunk(rwcw_pkg::TAG_DATA, 3);
    put_chunk(rwcw_pkg::TAG_FMT, 14);
    send_wav(rwcw_pkg::TAG_RIFF, riff_size(), rwcw_pkg::TAG_WAVE, 2);
    put_chunk(rwcw_pkg::TAG_FMT, 13);
    send_wav(rwcw_pkg::TAG_RIFF, riff_size(), rwcw_pkg::TAG_WAVE, 1);
    put_chunk(rwcw_pkg::TAG_FMT, 20);
    send_wav(rwcw_pkg::TAG_RIFF, riff_size(), rwcw_pkg::TAG_WAVE, 1);
    // empty data replaced later; empty chunk has no body
    put_chunk(rwcw_pkg::TAG_DATA, 0);
    put_chunk(TAG_LIST, 0);
    put_chunk(rwcw_pkg::TAG_FMT, 18);
    put_chunk(rwcw_pkg::TAG_DATA, 2);
    send_wav(rwcw_pkg::TAG_RIFF, riff_size(), rwcw_pkg::TAG_WAVE, 0);
    // first data kept; last header straddles the walk end
    put_chunk(rwcw_pkg::TAG_DATA, 6);
    put_chunk(rwcw_pkg::TAG_FMT, 16);
    put_chunk(rwcw_pkg::TAG_DATA, 2);
    put_header(TAG_LIST, 32'd0);
    send_wav(rwcw_pkg::TAG_RIFF, riff_size() - 32'd4, rwcw_pkg::TAG_WAVE, 1);
    // walk end beyond 32 bits, huge odd body, cut off by the next file
    put_header(rwcw_pkg::TAG_FMT, 32'hFFFF_FFFF);
    repeat (6) chunk_q.push_back(8'($urandom_range(0, 255)));
    send_wav(rwcw_pkg::TAG_RIFF, 32'hFFFF_FFFF, rwcw_pkg::TAG_WAVE, 0);
    put_chunk(rwcw_pkg::TAG_FMT, 16);
    put_header(rwcw_pkg::TAG_DATA, 32'hFFFF_FFFF);
    send_wav(rwcw_pkg::TAG_RIFF, 32'hFFFF_FFF8, rwcw_pkg::TAG_WAVE, 2);

    set_min_format(8'd255);
    // short fmt ends the walk at its length field
    put_header(rwcw_pkg::TAG_FMT, 32'd254);
    send_wav(rwcw_pkg::TAG_RIFF, riff_size(), rwcw_pkg::TAG_WAVE, 2);
    put_chunk(rwcw_pkg::TAG_FMT, 255);
    put_chunk(rwcw_pkg::TAG_DATA, 1);
    send_wav(rwcw_pkg::TAG_RIFF, riff_size(), rwcw_pkg::TAG_WAVE, 1);

    set_min_format(8'd0);
    put_chunk(rwcw_pkg::TAG_FMT, 0);
    put_chunk(rwcw_pkg::TAG_DATA, 0);
    send_wav(rwcw_pkg::TAG_RIFF, riff_size(), rwcw_pkg::TAG_WAVE, 1);
  endtask

  task automatic random_wav(input bit damaged);
    int          n_chunks;
    int          len;
    logic [31:0] riff_tag;
    logic [31:0] wave_tag;
    logic [31:0] rlen;
    logic [31:0] true_len;
    riff_tag = rwcw_pkg::TAG_RIFF;
    wave_tag = rwcw_pkg::TAG_WAVE;
    n_chunks = $urandom_range(0, 4);
    for (int k = 0; k < n_chunks; k++) begin
      case ($urandom_range(0, 10))
        0, 1, 2, 3: begin
          if ($urandom_range(0, 3) == 0) len = $urandom_range(0, 24);
          else len = min_fmt_now + int'($urandom_range(0, 3)) - 1;
          if (len < 0) len = 0;
          put_chunk(rwcw_pkg::TAG_FMT, len);
        end
        4, 5, 6, 7: begin
          len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          put_chunk(rwcw_pkg::TAG_DATA, len);
        end
        8, 9: put_chunk($urandom_range(0, 1) ? TAG_LIST : $urandom, $urandom_range(0, 9));
        default: begin
          // oversized length: a few body bytes, nothing after
          case ($urandom_range(0, 2))
            0: put_header(rwcw_pkg::TAG_FMT, $urandom | 32'h8000_0000);
            1: put_header(rwcw_pkg::TAG_DATA,
                          $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom);
            default: put_header(TAG_LIST, 32'hFFFF_FFFF - $urandom_range(0, 1));
          endcase
          repeat ($urandom_range(0, 6)) chunk_q.push_back(8'($urandom_range(0, 255)));
          k = n_chunks;
        end
      endcase
    end
    true_len = riff_size();
    case ($urandom_range(0, 9))
      6: rlen = $urandom_range(0, true_len);
      7: rlen = true_len + $urandom_range(1, 16);
      8: rlen = 32'hFFFF_FFFF - $urandom_range(0, 8);
      9: rlen = $urandom;
      default: rlen = true_len;
    endcase
    if (damaged) begin
      case ($urandom_range(0, 3))
        0: begin
          if ($urandom_range(0, 1)) riff_tag ^= 32'd1 << $urandom_range(0, 31);
          else wave_tag ^= 32'd1 << $urandom_range(0, 31);
        end
        1: begin
          if (chunk_q.size() > 0)
            chunk_q[$urandom_range(0, chunk_q.size() - 1)] ^= 8'($urandom_range(1, 255));
        end
        2: repeat ($urandom_range(0, chunk_q.size())) void'(chunk_q.pop_back());
        default: rlen = $urandom_range(0, 24);
      endcase
    end
    send_wav(riff_tag, rlen, wave_tag, $urandom_range(0, 3));
  endtask

  task automatic random_files(input int budget, input bit calm);
    int start;
    int pick;
    int n;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      case ($urandom_range(0, 3))
        0: idle_pct = 0;
        1: idle_pct = 8;
        2: idle_pct = 25;
        default: idle_pct = 50;
      endcase
      if (calm) idle_pct = 0;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        n = $urandom_range(2, 24);
        repeat (n) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        bytes_sent += n;
      end else begin
        random_wav(pick < 30);
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    directed_files();
    random_files(50, 1'b0);
    set_min_format(8'd16);
    random_files(50, 1'b0);
    set_min_format(8'($urandom_range(1, 40)));
    random_files(50, 1'b0);
    set_min_format(8'd14);
    random_files(60, 1'b1);

    item_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("[riff_wave_chunk_walker_core] OK");
    end else begin
      $display("[riff_wave_chunk_walker_core] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/rwcw_pkg.sv
sv/rwcw_step.sv
sv/rwcw_obuf.sv
sv/riff_wave_chunk_walker_core.sv
sim/riff_wave_chunk_walker_checker.sv
sim/tb_riff_wave_chunk_walker_core.sv
